// ===== hdl/i2cavg_pkg.sv =====
`timescale 1ns / 1ps

package i2cavg_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int STEP_W      = $clog2(SUM_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 3'd4;

    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd72;
    localparam logic [7:0]  RST_CONFIG_HIGH    = 8'd133;
    localparam logic [7:0]  RST_CONFIG_LOW     = 8'd131;
    localparam logic [6:0]  RST_SAMPLE_COUNT   = 7'd30;
    localparam logic [15:0] RST_SETTLE_TICKS   = 16'd1000;

    localparam logic [7:0] PTR_CONFIG     = 8'h01;
    localparam logic [7:0] PTR_CONVERSION = 8'h00;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_CSTART = 5'd1,
        PH_CADDR  = 5'd2,
        PH_CPTR   = 5'd3,
        PH_CHI    = 5'd4,
        PH_CLO    = 5'd5,
        PH_CSTOP  = 5'd6,
        PH_WAIT   = 5'd7,
        PH_PSTART = 5'd8,
        PH_PADDR  = 5'd9,
        PH_PPTR   = 5'd10,
        PH_PSTOP  = 5'd11,
        PH_RSTART = 5'd12,
        PH_RADDR  = 5'd13,
        PH_RMSB   = 5'd14,
        PH_RLSB   = 5'd15,
        PH_RSTOP  = 5'd16
    } t_phase;

    typedef struct packed {
        logic start_request;
        logic sda_in;
    } t_in_item;

    typedef struct packed {
        logic                scl_level;
        logic                sda_release;
        logic                busy_res;
        logic                average_valid;
        logic [SAMPLE_W-1:0] average_value;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [7:0]  config_high;
        logic [7:0]  config_low;
        logic [6:0]  sample_count;
        logic [15:0] settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic div_go;
    } t_step;

endpackage

// ===== hdl/i2c_adc_sampler_averager_unit.sv =====
// Ticked I2C master that averages converter readings. Each input beat is one SCL phase
// (start_request, sampled sda_in) and yields exactly one output beat with the SCL and SDA
// drive for that phase, busy_res, and the held average. A start request while idle runs
// sample_count rounds (0 runs one, more than MAX_SAMPLES runs MAX_SAMPLES) of config
// write, settle wait, pointer write and two-byte read, and the beat that closes the last
// read carries average_valid with floor(sum / samples). Timing: a beat's result is
// registered for the next clock; the beat that closes a measurement waits for the
// average from a restoring divider that retires one quotient bit per clock. The input
// is ready whenever the divider is idle and the output register is empty or being
// drained. The configuration port is always ready; write only between runs.
`timescale 1ns / 1ps

module i2c_adc_sampler_averager_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  i2cavg_pkg::t_in_item                i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output i2cavg_pkg::t_out_item               o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2cavg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cavg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import i2cavg_pkg::*;

    t_cfg                r_cfg;
    logic                r_out_valid;
    t_out_item           r_out;
    logic                r_div_wait;
    logic                r_hold_scl;
    logic                r_hold_sda;
    logic [SAMPLE_W-1:0] r_last_avg;

    logic                in_take;
    t_step               step;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
    logic                div_done;
    logic [SAMPLE_W-1:0] quot;

    assign o_in_ready  = !r_div_wait && (!r_out_valid || i_out_ready);
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    i2cavg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_take),
        .i_in    (i_in_data),
        .i_cfg   (r_cfg),
        .o_step  (step),
        .o_sum   (sum),
        .o_count (count)
    );

    i2cavg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (in_take && step.div_go),
        .i_dividend (sum),
        .i_divisor  (count),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEVICE_ADDRESS;
            r_cfg.config_high    <= RST_CONFIG_HIGH;
            r_cfg.config_low     <= RST_CONFIG_LOW;
            r_cfg.sample_count   <= RST_SAMPLE_COUNT;
            r_cfg.settle_ticks   <= RST_SETTLE_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[6:0];
                CFG_CONFIG_HIGH:    r_cfg.config_high    <= i_cfg_data[7:0];
                CFG_CONFIG_LOW:     r_cfg.config_low     <= i_cfg_data[7:0];
                CFG_SAMPLE_COUNT:   r_cfg.sample_count   <= i_cfg_data[6:0];
                CFG_SETTLE_TICKS:   r_cfg.settle_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_div_wait  <= 1'b0;
            r_last_avg  <= '0;
        end else begin
            if (div_done) begin
                r_out_valid <= 1'b1;
                r_div_wait  <= 1'b0;
                r_last_avg  <= quot;
            end else if (in_take) begin
                r_out_valid <= !step.div_go;
                r_div_wait  <= step.div_go;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat, or hold the bus levels until the quotient lands
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_out.scl_level     <= r_hold_scl;
            r_out.sda_release   <= r_hold_sda;
            r_out.busy_res      <= 1'b0;
            r_out.average_valid <= 1'b1;
            r_out.average_value <= quot;
        end else if (in_take) begin
            r_hold_scl          <= step.scl;
            r_hold_sda          <= step.sda;
            r_out.scl_level     <= step.scl;
            r_out.sda_release   <= step.sda;
            r_out.busy_res      <= step.busy;
            r_out.average_valid <= 1'b0;
            r_out.average_value <= r_last_avg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/i2cavg_div.sv =====
`timescale 1ns / 1ps

module i2cavg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [i2cavg_pkg::SUM_W-1:0]  i_dividend,
    input  logic [i2cavg_pkg::CNT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [i2cavg_pkg::SAMPLE_W-1:0] o_quot
);
    import i2cavg_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_dvs, n_dvs;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], fits};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo[SAMPLE_W-1:0];

endmodule

// ===== hdl/i2cavg_seq.sv =====
`timescale 1ns / 1ps

module i2cavg_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  i2cavg_pkg::t_in_item         i_in,
    input  i2cavg_pkg::t_cfg             i_cfg,
    output i2cavg_pkg::t_step            o_step,
    output logic [i2cavg_pkg::SUM_W-1:0] o_sum,
    output logic [i2cavg_pkg::CNT_W-1:0] o_count
);
    import i2cavg_pkg::*;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_bit, n_bit;
    logic [15:0]      r_wait, n_wait;
    logic [7:0]       r_shift, n_shift;
    logic [7:0]       r_high, n_high;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_done, n_done;

    logic             scl, sda, div_go;
    logic             ent;
    t_phase           ent_ph;
    logic             half;
    logic             bit_live;
    logic [CNT_W-1:0] eff_count;
    logic [CNT_W-1:0] done_inc;
    logic [15:0]      wait_inc;

    function automatic logic is_write(input t_phase p);
        return (p == PH_CADDR) || (p == PH_CPTR) || (p == PH_CHI) || (p == PH_CLO) ||
               (p == PH_PADDR) || (p == PH_PPTR) || (p == PH_RADDR);
    endfunction

    function automatic logic [7:0] byte_for(input t_phase p, input t_cfg c);
        logic [7:0] b;
        case (p)
            PH_CADDR, PH_PADDR: b = {c.device_address, 1'b0};
            PH_CPTR:            b = PTR_CONFIG;
            PH_CHI:             b = c.config_high;
            PH_CLO:             b = c.config_low;
            PH_RADDR:           b = {c.device_address, 1'b1};
            default:            b = PTR_CONVERSION;
        endcase
        return b;
    endfunction

    assign half     = r_wait[0];
    assign bit_live = !r_bit[3];
    assign done_inc = r_done + CNT_W'(1);
    assign wait_inc = r_wait + 16'd1;

    always_comb begin
        if (i_cfg.sample_count == 7'd0) begin
            eff_count = CNT_W'(1);
        end else if (int'(i_cfg.sample_count) > MAX_SAMPLES) begin
            eff_count = CNT_W'(MAX_SAMPLES);
        end else begin
            eff_count = CNT_W'(i_cfg.sample_count);
        end
    end

    // bus levels
    always_comb begin
        scl = 1'b1;
        sda = 1'b1;
        case (r_phase)
            PH_CSTART, PH_PSTART, PH_RSTART: begin
                sda = (r_wait == 16'd0);
            end
            PH_CADDR, PH_CPTR, PH_CHI, PH_CLO, PH_PADDR, PH_PPTR, PH_RADDR: begin
                scl = half;
                sda = bit_live ? r_shift[7] : 1'b1;
            end
            PH_RMSB, PH_RLSB: begin
                scl = half;
                sda = bit_live ? 1'b1 : (r_phase != PH_RMSB);
            end
            PH_CSTOP, PH_PSTOP, PH_RSTOP: begin
                if (r_wait == 16'd0) begin
                    scl = 1'b0;
                    sda = 1'b0;
                end else if (r_wait == 16'd1) begin
                    sda = 1'b0;
                end
            end
            default: begin
                scl = 1'b1;
                sda = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_wait  = r_wait;
        n_shift = r_shift;
        n_high  = r_high;
        n_sum   = r_sum;
        n_done  = r_done;
        div_go  = 1'b0;
        ent     = 1'b0;
        ent_ph  = PH_IDLE;
        case (r_phase)
            PH_CSTART, PH_PSTART, PH_RSTART: begin
                if (r_wait == 16'd0) begin
                    n_wait = 16'd1;
                end else begin
                    ent    = 1'b1;
                    ent_ph = t_phase'(r_phase + 5'd1);
                end
            end
            PH_CADDR, PH_CPTR, PH_CHI, PH_CLO, PH_PADDR, PH_PPTR, PH_RADDR: begin
                if (!half) begin
                    n_wait = 16'd1;
                end else if (bit_live) begin
                    n_wait  = 16'd0;
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                end else begin
                    ent    = 1'b1;
                    ent_ph = t_phase'(r_phase + 5'd1);
                end
            end
            PH_RMSB, PH_RLSB: begin
                if (!half) begin
                    n_wait = 16'd1;
                end else if (bit_live) begin
                    n_wait  = 16'd0;
                    n_shift = {r_shift[6:0], i_in.sda_in};
                    n_bit   = r_bit + 4'd1;
                end else begin
                    if (r_phase == PH_RMSB) begin
                        n_high = r_shift;
                    end
                    ent    = 1'b1;
                    ent_ph = t_phase'(r_phase + 5'd1);
                end
            end
            PH_CSTOP, PH_PSTOP, PH_RSTOP: begin
                if (r_wait == 16'd0) begin
                    n_wait = 16'd1;
                end else if (r_wait == 16'd1) begin
                    n_wait = 16'd2;
                end else if (r_phase == PH_CSTOP) begin
                    ent    = 1'b1;
                    ent_ph = (i_cfg.settle_ticks == 16'd0) ? PH_PSTART : PH_WAIT;
                end else if (r_phase == PH_PSTOP) begin
                    ent    = 1'b1;
                    ent_ph = PH_RSTART;
                end else begin
                    n_sum  = r_sum + SUM_W'({r_high, r_shift});
                    n_done = done_inc;
                    ent    = 1'b1;
                    if (done_inc >= eff_count) begin
                        div_go = 1'b1;
                        ent_ph = PH_IDLE;
                    end else begin
                        ent_ph = PH_CSTART;
                    end
                end
            end
            PH_WAIT: begin
                n_wait = wait_inc;
                if (wait_inc >= i_cfg.settle_ticks) begin
                    ent    = 1'b1;
                    ent_ph = PH_PSTART;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_in.start_request) begin
                    n_sum  = '0;
                    n_done = '0;
                    ent    = 1'b1;
                    ent_ph = PH_CSTART;
                end
            end
        endcase
        if (ent) begin
            n_phase = ent_ph;
            n_wait  = 16'd0;
            n_bit   = 4'd0;
            if (is_write(ent_ph)) begin
                n_shift = byte_for(ent_ph, i_cfg);
            end else if (ent_ph == PH_RMSB || ent_ph == PH_RLSB) begin
                n_shift = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_wait  <= '0;
            r_shift <= '0;
            r_high  <= '0;
            r_sum   <= '0;
            r_done  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_wait  <= n_wait;
            r_shift <= n_shift;
            r_high  <= n_high;
            r_sum   <= n_sum;
            r_done  <= n_done;
        end
    end

    assign o_step.scl    = scl;
    assign o_step.sda    = sda;
    assign o_step.busy   = (n_phase != PH_IDLE);
    assign o_step.div_go = div_go;
    assign o_sum         = n_sum;
    assign o_count       = n_done;

endmodule

// ===== hdl/i2cavg_chk.sv =====
`timescale 1ns / 1ps

module i2cavg_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input i2cavg_pkg::t_out_item o_out_data
);
    import i2cavg_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // no input taken while a result sits unread
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> i_out_ready)
        else $error("input ready with output blocked");

    // average beat closes the run
    a_avg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.average_valid |->
            !o_out_data.busy_res && o_out_data.scl_level && o_out_data.sda_release)
        else $error("average beat with bus not released");

    // no output right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind i2c_adc_sampler_averager_unit i2cavg_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import i2cavg_pkg::*;

    typedef struct packed {
        logic start;
        logic sda;
        logic typed;
        logic scl_o;
        logic sda_o;
        logic busy_o;
    } t_row;

    localparam int ROWS = 16;
    localparam int SDA_RANDOM = 0;
    localparam int SDA_ONES   = 1;
    localparam int SDA_ZEROS  = 2;

    // start, sda_in, typed, then the typed scl, sda and busy; average is zero on all of them
    localparam logic [5:0] DIRECTED [ROWS] = '{
        6'b011_110,   // idle after reset
        6'b101_111,   // start taken, bus still idle
        6'b011_111,   // start condition, first half
        6'b111_101,   // start condition, second half, request ignored
        6'b001_011,   // address bit 7 = 1
        6'b011_111,
        6'b001_001,   // address bit 6 = 0
        6'b011_101,
        6'b001_001,   // address bit 5 = 0
        6'b011_101,
        6'b001_011,   // address bit 4 = 1
        6'b111_111,
        6'b010_000,
        6'b100_000,
        6'b010_000,
        6'b100_000
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_beat;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_beat;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                    idle_on;
    int                    fail_cnt;
    int                    ticks_sent;
    t_out_item             beats_due [$];

    // bus master mirror
    t_cfg                  regs;
    t_phase                ph;
    logic [3:0]            bit_no;
    logic [15:0]           ph_tick;
    logic [7:0]            shifter;
    logic [7:0]            msb_hold;
    logic [SUM_W-1:0]      acc_sum;
    logic [6:0]            n_taken;
    logic [15:0]           avg_out;

    i2c_adc_sampler_averager_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #150_000_000;
        $display("i2c_adc_sampler_averager_unit regression: fail");
        $finish;
    end

    function automatic void enter_phase(input t_phase nxt);
        ph = nxt;
        ph_tick = '0;
        bit_no = '0;
        case (nxt)
            PH_CADDR, PH_PADDR: shifter = {regs.device_address, 1'b0};
            PH_RADDR:           shifter = {regs.device_address, 1'b1};
            PH_CPTR:            shifter = PTR_CONFIG;
            PH_PPTR:            shifter = PTR_CONVERSION;
            PH_CHI:             shifter = regs.config_high;
            PH_CLO:             shifter = regs.config_low;
            PH_RMSB, PH_RLSB:   shifter = '0;
            default: ;
        endcase
    endfunction

    function automatic t_out_item predict_bus_beat(input t_in_item it);
        t_out_item r;
        logic      half;
        logic [6:0] lim;
        r.scl_level = 1'b1;
        r.sda_release = 1'b1;
        r.average_valid = 1'b0;
        half = ph_tick[0];
        case (ph)
            PH_CSTART, PH_PSTART, PH_RSTART: begin
                r.sda_release = (ph_tick == 0);
                if (ph_tick == 0) ph_tick = 16'd1;
                else enter_phase(t_phase'(ph + 5'd1));
            end
            PH_CADDR, PH_CPTR, PH_CHI, PH_CLO, PH_PADDR, PH_PPTR, PH_RADDR: begin
                r.scl_level = half;
                r.sda_release = (bit_no < 8) ? shifter[7] : 1'b1;
                if (!half) begin
                    ph_tick = 16'd1;
                end else if (bit_no < 8) begin
                    ph_tick = '0;
                    shifter = {shifter[6:0], 1'b0};
                    bit_no++;
                end else begin
                    enter_phase(t_phase'(ph + 5'd1));
                end
            end
            PH_RMSB, PH_RLSB: begin
                r.scl_level = half;
                r.sda_release = (bit_no < 8) ? 1'b1 : (ph != PH_RMSB);
                if (!half) begin
                    ph_tick = 16'd1;
                end else if (bit_no < 8) begin
                    ph_tick = '0;
                    shifter = {shifter[6:0], it.sda_in};
                    bit_no++;
                end else begin
                    if (ph == PH_RMSB) msb_hold = shifter;
                    enter_phase(t_phase'(ph + 5'd1));
                end
            end
            PH_CSTOP, PH_PSTOP, PH_RSTOP: begin
                if (ph_tick == 0) begin
                    r.scl_level = 1'b0;
                    r.sda_release = 1'b0;
                    ph_tick = 16'd1;
                end else if (ph_tick == 1) begin
                    r.sda_release = 1'b0;
                    ph_tick = 16'd2;
                end else if (ph == PH_CSTOP) begin
                    enter_phase((regs.settle_ticks == 0) ? PH_PSTART : PH_WAIT);
                end else if (ph == PH_PSTOP) begin
                    enter_phase(PH_RSTART);
                end else begin
                    acc_sum = acc_sum + SUM_W'({msb_hold, shifter});
                    n_taken++;
                    lim = regs.sample_count;
                    if (lim == 0) lim = 7'd1;
                    if (lim > MAX_SAMPLES) lim = 7'(MAX_SAMPLES);
                    if (n_taken >= lim) begin
                        avg_out = 16'(acc_sum / n_taken);
                        r.average_valid = 1'b1;
                        enter_phase(PH_IDLE);
                    end else begin
                        enter_phase(PH_CSTART);
                    end
                end
            end
            PH_WAIT: begin
                ph_tick = ph_tick + 16'd1;
                if (ph_tick >= regs.settle_ticks) enter_phase(PH_PSTART);
            end
            default: begin
                ph = PH_IDLE;
                if (it.start_request) begin
                    acc_sum = '0;
                    n_taken = '0;
                    enter_phase(PH_CSTART);
                end
            end
        endcase
        r.busy_res = (ph != PH_IDLE);
        r.average_value = avg_out;
        return r;
    endfunction

    function automatic logic sda_bit(input int mode);
        if (mode == SDA_ONES) return 1'b1;
        if (mode == SDA_ZEROS) return 1'b0;
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic flag_beat(input string why, input t_out_item want, input t_out_item got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s: expected scl=%0b sda=%0b busy=%0b valid=%0b avg=%0d,",
                     why, want.scl_level, want.sda_release, want.busy_res,
                     want.average_valid, want.average_value,
                     " got scl=%0b sda=%0b busy=%0b valid=%0b avg=%0d",
                     got.scl_level, got.sda_release, got.busy_res,
                     got.average_valid, got.average_value);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (beats_due.size() == 0) begin
                flag_beat("beat with nothing due", '0, out_beat);
            end else begin
                want = beats_due.pop_front();
                if (out_beat.scl_level !== want.scl_level
                        || out_beat.sda_release !== want.sda_release
                        || out_beat.busy_res !== want.busy_res
                        || out_beat.average_valid !== want.average_valid
                        || out_beat.average_value !== want.average_value)
                    flag_beat("beat mismatch", want, out_beat);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic start, input logic sda, input bit typed = 1'b0,
                             input t_out_item want = '0);
        int        gap;
        t_in_item  it;
        t_out_item due;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        it.start_request = start;
        it.sda_in = sda;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= it;
        do @(posedge clk); while (!in_ready);
        due = predict_bus_beat(it);
        beats_due.push_back(typed ? want : due);
        ticks_sent++;
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (beats_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DEVICE_ADDRESS: regs.device_address = val[6:0];
            CFG_CONFIG_HIGH:    regs.config_high = val[7:0];
            CFG_CONFIG_LOW:     regs.config_low = val[7:0];
            CFG_SAMPLE_COUNT:   regs.sample_count = val[6:0];
            CFG_SETTLE_TICKS:   regs.settle_ticks = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] addr, input logic [15:0] hi,
                                 input logic [15:0] lo, input logic [15:0] cnt,
                                 input logic [15:0] settle);
        hold_input();
        wait_drained();
        write_reg(CFG_DEVICE_ADDRESS, addr);
        write_reg(CFG_CONFIG_HIGH, hi);
        write_reg(CFG_CONFIG_LOW, lo);
        write_reg(CFG_SAMPLE_COUNT, cnt);
        write_reg(CFG_SETTLE_TICKS, settle);
    endtask

    // busy ticks may carry stray start requests, they are ignored
    task automatic finish_measurement(input int mode);
        while (ph != PH_IDLE) send_tick(1'($urandom_range(0, 1)), sda_bit(mode));
    endtask

    task automatic measure(input int mode);
        send_tick(1'b1, sda_bit(mode));
        finish_measurement(mode);
    endtask

    task automatic random_setting();
        apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 40))
                                                  : 16'($urandom_range(0, 6)));
    endtask

    initial begin
        t_row      row;
        t_out_item want;
        int        base;
        int        burst;
        int        mode;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_on = 1'b1;
        fail_cnt = 0;
        ticks_sent = 0;

        regs.device_address = RST_DEVICE_ADDRESS;
        regs.config_high = RST_CONFIG_HIGH;
        regs.config_low = RST_CONFIG_LOW;
        regs.sample_count = RST_SAMPLE_COUNT;
        regs.settle_ticks = RST_SETTLE_TICKS;
        ph = PH_IDLE;
        bit_no = '0;
        ph_tick = '0;
        shifter = '0;
        msb_hold = '0;
        acc_sum = '0;
        n_taken = '0;
        avg_out = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one short sample, power-up address
        write_reg(CFG_SAMPLE_COUNT, 16'd1);
        write_reg(CFG_SETTLE_TICKS, 16'd5);

        for (int k = 0; k < ROWS; k++) begin
            row = t_row'(DIRECTED[k]);
            want = '0;
            want.scl_level = row.scl_o;
            want.sda_release = row.sda_o;
            want.busy_res = row.busy_o;
            send_tick(row.start, row.sda, row.typed, want);
        end
        finish_measurement(SDA_RANDOM);

        // count of zero, then both data extremes
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd40);
        measure(SDA_ONES);
        apply_setting(16'd127, 16'd255, 16'd255, 16'd1, 16'd0);
        measure(SDA_ONES);
        apply_setting(16'd85, 16'hA5, 16'h5A, 16'd1, 16'd1);
        measure(SDA_ZEROS);

        base = ticks_sent;
        while (ticks_sent - base < 400) begin
            random_setting();
            mode = ($urandom_range(0, 4) == 0) ? $urandom_range(SDA_ONES, SDA_ZEROS)
                                               : SDA_RANDOM;
            burst = $urandom_range(80, 220);
            repeat (burst) begin
                if ($urandom_range(0, 99) == 0) begin
                    hold_input();
                    wait_drained();
                end
                send_tick(1'($urandom_range(0, 1)), sda_bit(mode));
            end
            finish_measurement(mode);
        end

        idle_on = 1'b0;
        random_setting();
        repeat (60) send_tick(1'($urandom_range(0, 1)), sda_bit(SDA_RANDOM));
        finish_measurement(SDA_RANDOM);

        hold_input();
        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_cnt == 0 && beats_due.size() == 0) begin
            $display("i2c_adc_sampler_averager_unit regression: pass");
        end else begin
            $display("i2c_adc_sampler_averager_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/i2cavg_pkg.sv
hdl/i2cavg_div.sv
hdl/i2cavg_seq.sv
hdl/i2c_adc_sampler_averager_unit.sv
hdl/i2cavg_chk.sv
tb/testbench.sv
